>>> sv/ajb_pkg.sv
// shared constants, codes and types of the audio jitter buffer
package ajb_pkg;

   // packet and ring geometry
   localparam int PACKET_SAMPLES = 16;
   localparam int PKT_AW         = $clog2(PACKET_SAMPLES);
   localparam int STAGE_DEPTH    = 2 * PACKET_SAMPLES;
   localparam int STAGE_AW       = $clog2(STAGE_DEPTH);
   localparam int RING_SAMPLES   = 256;
   localparam int RING_AW        = $clog2(RING_SAMPLES);
   localparam int UPSAMPLE       = 2;
   localparam int UP_W           = $clog2(UPSAMPLE);

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int FRAME_W    = 6;
   localparam int MQP_W      = 4;
   localparam int NFR_W      = 7;
   localparam int CH_W       = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   // register limits and reset values
   localparam int MAX_FRAMES   = 64;
   localparam int MAX_CHANNELS = 8;
   localparam logic [MQP_W-1:0] MQP_RESET = MQP_W'(4);
   localparam logic [NFR_W-1:0] NFR_RESET = NFR_W'(32);
   localparam logic [CH_W-1:0]  CH_RESET  = CH_W'(2);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_QUEUED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS   = 2'd2;

   // input operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FRAME  = 1'b1;

   // command queue
   localparam int CMD_DEPTH = 4;
   localparam int CMD_AW    = $clog2(CMD_DEPTH);

   typedef enum logic {
      CMD_COMMIT = 1'b0,
      CMD_PLAY   = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         bank;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } done_type;

   typedef struct packed {
      logic [MQP_W-1:0] max_queued;
      logic [NFR_W-1:0] frames;
      logic [CH_W-1:0]  channels;
   } cfg_type;

endpackage

>>> sv/ajb_ram.sv
// generic single write port, single registered read port ram
module ajb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/ajb_front.sv
// front end: accepts transactions, stages packet samples, queues commands
module ajb_front import ajb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  stage_wr_en,
   output logic [STAGE_AW-1:0]   stage_wr_addr,
   output logic [SAMPLE_W-1:0]   stage_wr_data,
   output logic                  cmd_push,
   output cmd_type               cmd_data,
   input  logic                  cmd_full,
   input  done_type              done
);

   logic [PKT_AW:0] cnt_ff, cnt_in;
   logic            bank_ff, bank_in;
   logic [1:0]      busy_ff, busy_in;
   logic            accept;
   logic            is_frame;
   logic [PKT_AW:0] cnt_inc;
   logic            commit;

   // accept only when a command slot is free and the staging bank is free
   assign req_tready = !cmd_full && !busy_ff[bank_ff];
   assign accept     = req_tvalid && req_tready;
   assign is_frame   = (req_tuser == OP_FRAME);

   // staging write, excess samples are dropped
   assign stage_wr_en   = accept && !is_frame && !cnt_ff[PKT_AW];
   assign stage_wr_addr = {bank_ff, cnt_ff[PKT_AW-1:0]};
   assign stage_wr_data = req_tdata[SAMPLE_W-1:0];
   assign cnt_inc       = cnt_ff + {{PKT_AW{1'b0}}, stage_wr_en};

   // full packet at its end commits, frame request plays
   assign commit   = accept && !is_frame && req_tlast
                     && (cnt_inc == (PKT_AW+1)'(PACKET_SAMPLES));
   assign cmd_push = (accept && is_frame) || commit;
   always_comb begin
      cmd_data.kind = is_frame ? CMD_PLAY : CMD_COMMIT;
      cmd_data.bank = bank_ff;
   end

   // next state of staging count, bank and busy flags
   always_comb begin
      cnt_in  = cnt_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (accept && !is_frame) begin
         cnt_in = req_tlast ? '0 : cnt_inc;
      end
      if (done.valid) begin
         busy_in[done.bank] = 1'b0;
      end
      if (commit) begin
         busy_in[bank_ff] = 1'b1;
         bank_in          = !bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

>>> sv/ajb_cmd_fifo.sv
// short command queue between front and back end
module ajb_cmd_fifo import ajb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    not_empty
);

   cmd_type         slot_ff [CMD_DEPTH];
   logic [CMD_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CMD_AW:0]   count_ff;
   logic              do_push, do_pop;

   assign full      = (count_ff == (CMD_AW+1)'(CMD_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (CMD_AW+1)'(do_push) - (CMD_AW+1)'(do_pop);
      end
   end

endmodule

>>> sv/ajb_back.sv
// back end: copies packets into the ring and plays frame blocks
module ajb_back import ajb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  cmd_valid,
   input  cmd_type               cmd_data,
   output logic                  cmd_pop,
   output logic                  stage_rd_en,
   output logic [STAGE_AW-1:0]   stage_rd_addr,
   input  logic [SAMPLE_W-1:0]   stage_rd_data,
   output done_type              done,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_COPY    = 5'b00010,
      S_PLAY_RD = 5'b00100,
      S_PLAY_OUT = 5'b01000,
      S_SILENT  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [RING_AW-1:0]    wp_ff, wp_in;
   logic [RING_AW-1:0]    rp_ff, rp_in;
   logic                  bank_ff, bank_in;
   logic [PKT_AW:0]       cnt_ff, cnt_in;
   logic [PKT_AW-1:0]     n_ff, n_in;
   logic [UP_W-1:0]       u_ff, u_in;
   logic [FRAME_W-1:0]    frm_ff, frm_in;
   logic [NFR_W-1:0]      nfr_ff, nfr_in;
   logic [CH_W-1:0]       ch_ff, ch_in;

   logic                  rsp_valid_ff;
   logic [FRAME_W-1:0]    rsp_idx_ff;
   logic [SAMPLE_W-1:0]   rsp_smp_ff;
   logic [CH_W-1:0]       rsp_ch_ff;
   logic                  rsp_sil_ff;
   logic                  rsp_last_ff;

   logic                  out_free;
   logic                  emit;
   logic [FRAME_W-1:0]    emit_idx;
   logic [SAMPLE_W-1:0]   emit_smp;
   logic                  emit_sil;
   logic                  emit_last;

   logic [RING_AW-1:0]    fill;
   logic [MQP_W-1:0]      mq_eff;
   logic [RING_AW-1:0]    limit;
   logic [RING_AW-1:0]    skip_rp;
   logic [NFR_W-1:0]      nfr_eff;
   logic [CH_W-1:0]       ch_eff;
   logic [PKT_AW:0]       cw;
   logic                  ring_wr_en;
   logic [RING_AW-1:0]    ring_wr_addr;
   logic                  ring_rd_en;
   logic [RING_AW-1:0]    ring_rd_addr;
   logic [SAMPLE_W-1:0]   ring_rd_data;
   logic                  play_last;
   logic                  silent_last;

   // fill level, skip target and clamped registers
   assign fill    = wp_ff - rp_ff;
   assign mq_eff  = (cfg.max_queued == '0) ? MQP_W'(1) : cfg.max_queued;
   assign limit   = RING_AW'(mq_eff) * RING_AW'(PACKET_SAMPLES);
   assign skip_rp = (fill > limit) ? (wp_ff - limit) : rp_ff;
   always_comb begin
      if (cfg.frames == '0) begin
         nfr_eff = NFR_W'(1);
      end else if (cfg.frames > NFR_W'(MAX_FRAMES)) begin
         nfr_eff = NFR_W'(MAX_FRAMES);
      end else begin
         nfr_eff = cfg.frames;
      end
      if (cfg.channels == '0) begin
         ch_eff = CH_W'(1);
      end else if (cfg.channels > CH_W'(MAX_CHANNELS)) begin
         ch_eff = CH_W'(MAX_CHANNELS);
      end else begin
         ch_eff = cfg.channels;
      end
   end

   // packet copy: each ring write follows its staging read in the next cycle
   assign stage_rd_en   = (state_ff == S_COPY) && !cnt_ff[PKT_AW];
   assign stage_rd_addr = {bank_ff, cnt_ff[PKT_AW-1:0]};
   assign cw            = cnt_ff - 1'b1;
   assign ring_wr_en    = (state_ff == S_COPY) && (cnt_ff != '0);
   assign ring_wr_addr  = wp_ff + RING_AW'(cw[PKT_AW-1:0]);

   // playback read
   assign ring_rd_en   = (state_ff == S_PLAY_RD);
   assign ring_rd_addr = rp_ff + RING_AW'(n_ff);

   ajb_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_SAMPLES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (stage_rd_data),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   // frame generation
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign play_last   = (n_ff == PKT_AW'(PACKET_SAMPLES - 1)) && (u_ff == UP_W'(UPSAMPLE - 1));
   assign silent_last = (NFR_W'(frm_ff) == nfr_ff - 1'b1);
   always_comb begin
      emit      = 1'b0;
      emit_idx  = frm_ff;
      emit_smp  = '0;
      emit_sil  = 1'b1;
      emit_last = silent_last;
      if (state_ff == S_PLAY_OUT) begin
         emit      = out_free;
         emit_idx  = FRAME_W'({n_ff, u_ff});
         emit_smp  = ring_rd_data;
         emit_sil  = 1'b0;
         emit_last = play_last;
      end else if (state_ff == S_SILENT) begin
         emit = out_free;
      end
   end

   // command sequencing
   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      bank_in  = bank_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      u_in     = u_ff;
      frm_in   = frm_ff;
      nfr_in   = nfr_ff;
      ch_in    = ch_ff;
      cmd_pop  = 1'b0;
      done     = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd_data.kind == CMD_COMMIT) begin
                  bank_in  = cmd_data.bank;
                  cnt_in   = '0;
                  state_in = S_COPY;
               end else begin
                  rp_in  = skip_rp;
                  ch_in  = ch_eff;
                  nfr_in = nfr_eff;
                  n_in   = '0;
                  u_in   = '0;
                  frm_in = '0;
                  if (fill < RING_AW'(PACKET_SAMPLES)) begin
                     state_in = S_SILENT;
                  end else begin
                     state_in = S_PLAY_RD;
                  end
               end
            end
         end
         S_COPY: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[PKT_AW]) begin
               wp_in      = wp_ff + RING_AW'(PACKET_SAMPLES);
               done.valid = 1'b1;
               done.bank  = bank_ff;
               state_in   = S_IDLE;
            end
         end
         S_PLAY_RD: begin
            u_in     = '0;
            state_in = S_PLAY_OUT;
         end
         S_PLAY_OUT: begin
            if (emit) begin
               if (u_ff != UP_W'(UPSAMPLE - 1)) begin
                  u_in = u_ff + 1'b1;
               end else if (play_last) begin
                  rp_in    = rp_ff + RING_AW'(PACKET_SAMPLES);
                  state_in = S_IDLE;
               end else begin
                  n_in     = n_ff + 1'b1;
                  state_in = S_PLAY_RD;
               end
            end
         end
         S_SILENT: begin
            if (emit) begin
               frm_in = frm_ff + 1'b1;
               if (silent_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff    <= '0;
         rp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff <= bank_in;
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      u_ff    <= u_in;
      frm_ff  <= frm_in;
      nfr_ff  <= nfr_in;
      ch_ff   <= ch_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_idx_ff  <= emit_idx;
         rsp_smp_ff  <= emit_smp;
         rsp_ch_ff   <= ch_ff;
         rsp_sil_ff  <= emit_sil;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ch_ff, rsp_smp_ff, rsp_idx_ff});
   assign rsp_tuser  = rsp_sil_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // write pointer moves only at the end of a packet copy
   a_wp_only_in_copy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_COPY) |=> $stable(wp_ff))
      else $error("write pointer moved outside packet copy");

   // frames come only from playback or silence states
   a_emit_state: assert property (@(posedge clock) disable iff (reset)
      emit |-> (state_ff == S_PLAY_OUT || state_ff == S_SILENT))
      else $error("frame emitted in wrong state");

   // staging bank is released only by a finishing copy
   a_done_from_copy: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> (state_ff == S_COPY && cnt_ff[PKT_AW]))
      else $error("bank released outside copy");

   // a command is never taken while a block is in progress
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == S_IDLE && cmd_valid))
      else $error("command taken while busy");
`endif

endmodule

>>> sv/audio_jitter_buffer.sv
// top level of the audio jitter buffer: registers, staging ram, front and back
//
//  channel | direction | transaction                | tdata (low bit up)        | tuser  | tlast
//  req     | in        | packet sample or frame req | sample_in[15:0]           | op     | packet_end
//  rsp     | out       | one output frame           | frame_index, sample_out,  | silent | block_last
//          |           |                            | channels, 6 zero bits     |        |
//  csr     | in        | register write             | index 0..2, data 7 bits   |        |
//
//  a sample transaction is taken in the cycle it is offered while req_tready is high;
//  a full packet is copied into the ring by the back end while further samples go to
//  the other bank; a frame block does one ring read and gives two frames per packet
//  sample, or frames_per_block silent frames on underrun; stalls on rsp hold the back end
//  reset clears pointers, front and queue counts and control, not back-end counters or ring contents
//  the command queue lets req keep flowing until it fills or the staging bank is busy
module audio_jitter_buffer import ajb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample_in[15:0]
   input  logic                  req_tuser,   // op
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // frame_index[5:0], sample_out[21:6], channels[25:22]
   output logic                  rsp_tuser,   // silent
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type               cfg_ff;
   logic                  stage_wr_en;
   logic [STAGE_AW-1:0]   stage_wr_addr;
   logic [SAMPLE_W-1:0]   stage_wr_data;
   logic                  stage_rd_en;
   logic [STAGE_AW-1:0]   stage_rd_addr;
   logic [SAMPLE_W-1:0]   stage_rd_data;
   logic                  cmd_push;
   cmd_type               cmd_push_data;
   logic                  cmd_full;
   logic                  cmd_pop;
   cmd_type               cmd_pop_data;
   logic                  cmd_valid;
   done_type              done;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_queued <= MQP_RESET;
         cfg_ff.frames     <= NFR_RESET;
         cfg_ff.channels   <= CH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_QUEUED: cfg_ff.max_queued <= csr_wdata[MQP_W-1:0];
            CSR_FRAMES:     cfg_ff.frames     <= csr_wdata[NFR_W-1:0];
            CSR_CHANNELS:   cfg_ff.channels   <= csr_wdata[CH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ajb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .stage_wr_en   (stage_wr_en),
      .stage_wr_addr (stage_wr_addr),
      .stage_wr_data (stage_wr_data),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_push_data),
      .cmd_full      (cmd_full),
      .done          (done)
   );

   // two staging banks of one packet each
   ajb_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STAGE_DEPTH)
   ) u_stage (
      .clock   (clock),
      .wr_en   (stage_wr_en),
      .wr_addr (stage_wr_addr),
      .wr_data (stage_wr_data),
      .rd_en   (stage_rd_en),
      .rd_addr (stage_rd_addr),
      .rd_data (stage_rd_data)
   );

   ajb_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .not_empty (cmd_valid)
   );

   ajb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd_valid     (cmd_valid),
      .cmd_data      (cmd_pop_data),
      .cmd_pop       (cmd_pop),
      .stage_rd_en   (stage_rd_en),
      .stage_rd_addr (stage_rd_addr),
      .stage_rd_data (stage_rd_data),
      .done          (done),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

endmodule
